// ===== design/datetime_to_cmos_rtc_bytes_core_defines.svh =====
// Assertion macros for the RTC byte encoder checker.
`ifndef DATETIME_TO_CMOS_RTC_BYTES_CORE_DEFINES_SVH
`define DATETIME_TO_CMOS_RTC_BYTES_CORE_DEFINES_SVH

// Implication checked at every rising edge of clk outside reset.
`define DTRTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every rising edge of clk outside reset.
`define DTRTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== design/dtrtc_pkg.sv =====
// Types, constants and helper functions for the RTC byte encoder.
`timescale 1ns / 1ps
package dtrtc_pkg;

  localparam logic [7:0]  CTL_24H    = 8'h02;
  localparam logic [7:0]  CTL_BIN    = 8'h04;
  localparam logic [7:0]  PM_FLAG    = 8'h80;
  localparam logic [7:0]  FMT_RESET  = 8'h02;
  localparam logic [13:0] YEAR_MIN   = 14'd2000;
  localparam logic [13:0] YEAR_MAX   = 14'd2099;
  localparam logic [6:0]  CENTURY    = 7'd20;
  localparam logic [4:0]  HOUR_LIMIT = 5'd24;
  localparam logic [4:0]  HOUR_HALF  = 5'd12;
  localparam logic [5:0]  MIN_LIMIT  = 6'd60;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  typedef struct packed {
    logic       invalid;
    logic [7:0] second_reg;
    logic [7:0] minute_reg;
    logic [7:0] hour_reg;
    logic [7:0] day_reg;
    logic [7:0] month_reg;
    logic [7:0] year_reg;
    logic [7:0] century_reg;
  } result_t;

  // Month length; zero for month codes outside 1..12.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      MONTH_FEB:                                  d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Two-digit BCD of a value below 100; tens by reciprocal multiply (205/2048).
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = {8'd0, v} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones     = v - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== design/datetime_to_cmos_rtc_bytes_core.sv =====
// Top level of the date and time to CMOS RTC byte encoder.
`timescale 1ns / 1ps
// Converts a calendar date and time to the seven RTC register bytes. A transfer
// is taken whenever start is high; busy never rises, so one item may be offered
// every cycle. Each transfer passes the input register and then the result
// register, and its result is shown for a single cycle marked by out_valid: the
// receiver cannot stall. The two registers lie around the one pass of validation
// and encoding logic. cfg_wdata is taken when cfg_we is high; write it only while
// no item is in flight. Invalid input raises out_invalid with all bytes zero.
module datetime_to_cmos_rtc_bytes_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_invalid,
  output logic [7:0]  out_second_reg,
  output logic [7:0]  out_minute_reg,
  output logic [7:0]  out_hour_reg,
  output logic [7:0]  out_day_reg,
  output logic [7:0]  out_month_reg,
  output logic [7:0]  out_year_reg,
  output logic [7:0]  out_century_reg
);
  import dtrtc_pkg::*;

  logic [7:0] fmt_r;
  logic       in_vld_r;
  datetime_t  in_r;
  logic       out_vld_r;
  result_t    res_r;
  result_t    res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= '{year: in_year, month: in_month, day: in_day,
                hour: in_hour, minute: in_minute, second: in_second};
    end
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  dtrtc_encode u_encode (
    .dt  (in_r),
    .fmt (fmt_r),
    .res (res_nxt)
  );

  assign out_valid       = out_vld_r;
  assign out_invalid     = res_r.invalid;
  assign out_second_reg  = res_r.second_reg;
  assign out_minute_reg  = res_r.minute_reg;
  assign out_hour_reg    = res_r.hour_reg;
  assign out_day_reg     = res_r.day_reg;
  assign out_month_reg   = res_r.month_reg;
  assign out_year_reg    = res_r.year_reg;
  assign out_century_reg = res_r.century_reg;

endmodule

// ===== design/dtrtc_encode.sv =====
// Validation and BCD/binary encoding of one date and time.
`timescale 1ns / 1ps
module dtrtc_encode (
  input  dtrtc_pkg::datetime_t dt,
  input  logic [7:0]           fmt,
  output dtrtc_pkg::result_t   res
);
  import dtrtc_pkg::*;

  logic        leap;
  logic        ok;
  logic        pm;
  logic        bin;
  logic [4:0]  hour_adj;
  logic [13:0] year_off;
  logic [6:0]  yy;

  function automatic logic [7:0] enc(input logic [6:0] v, input logic binary);
    return binary ? {1'b0, v} : to_bcd(v);
  endfunction

  // Within 2000..2099 the century rule never applies beyond 2000 itself, a leap year
  assign leap     = (dt.year[1:0] == 2'b00);
  assign year_off = dt.year - YEAR_MIN;
  assign yy       = year_off[6:0];
  assign bin      = |(fmt & CTL_BIN);

  assign ok = (dt.year >= YEAR_MIN) && (dt.year <= YEAR_MAX) &&
              (dt.day != 5'd0) && (dt.day <= month_days(dt.month, leap)) &&
              (dt.hour < HOUR_LIMIT) && (dt.minute < MIN_LIMIT) &&
              (dt.second < MIN_LIMIT);

  always_comb begin
    pm       = 1'b0;
    hour_adj = dt.hour;
    if ((fmt & CTL_24H) == 8'h00) begin
      pm = (dt.hour >= HOUR_HALF);
      if (pm) begin
        hour_adj = dt.hour - HOUR_HALF;
      end
      if (hour_adj == 5'd0) begin
        hour_adj = HOUR_HALF;
      end
    end
  end

  always_comb begin
    res = '0;
    if (!ok) begin
      res.invalid = 1'b1;
    end else begin
      res.second_reg  = enc({1'b0, dt.second}, bin);
      res.minute_reg  = enc({1'b0, dt.minute}, bin);
      res.hour_reg    = enc({2'b00, hour_adj}, bin) | (pm ? PM_FLAG : 8'h00);
      res.day_reg     = enc({2'b00, dt.day}, bin);
      res.month_reg   = enc({3'b000, dt.month}, bin);
      res.year_reg    = enc(yy, bin);
      res.century_reg = enc(CENTURY, bin);
    end
  end

endmodule

// ===== design/dtrtc_checker.sv =====
// Port-level checks for the RTC byte encoder, bound to the top level.
`timescale 1ns / 1ps
`include "datetime_to_cmos_rtc_bytes_core_defines.svh"
module dtrtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_invalid,
  input logic [7:0] out_second_reg,
  input logic [7:0] out_minute_reg,
  input logic [7:0] out_hour_reg,
  input logic [7:0] out_day_reg,
  input logic [7:0] out_month_reg,
  input logic [7:0] out_year_reg,
  input logic [7:0] out_century_reg
);

  // each transfer gives exactly one result
  `DTRTC_ASSERT_IMP(a_result_follows, start && !busy, ##2 out_valid, "result missing")
  `DTRTC_ASSERT_IMP(a_no_spurious, out_valid, $past(start && !busy && rst_n, 2), "extra result")
  `DTRTC_ASSERT_IMP(a_invalid_zero, out_valid && out_invalid,
    (out_second_reg | out_minute_reg | out_hour_reg | out_day_reg | out_month_reg |
     out_year_reg | out_century_reg) == 8'h00, "invalid result carries data")
  `DTRTC_ASSERT_IMP(a_century, out_valid && !out_invalid,
    out_century_reg == 8'h20 || out_century_reg == 8'd20, "century not twenty")

endmodule

bind datetime_to_cmos_rtc_bytes_core dtrtc_checker u_dtrtc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_invalid     (out_invalid),
  .out_second_reg  (out_second_reg),
  .out_minute_reg  (out_minute_reg),
  .out_hour_reg    (out_hour_reg),
  .out_day_reg     (out_day_reg),
  .out_month_reg   (out_month_reg),
  .out_year_reg    (out_year_reg),
  .out_century_reg (out_century_reg)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the date and time to CMOS RTC byte encoder.
`timescale 1ns / 1ps
module tb_top;
  import dtrtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [13:0] in_year = '0;
  logic [3:0]  in_month = '0;
  logic [4:0]  in_day = '0;
  logic [4:0]  in_hour = '0;
  logic [5:0]  in_minute = '0;
  logic [5:0]  in_second = '0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        out_valid;
  logic        out_invalid;
  logic [7:0]  out_second_reg;
  logic [7:0]  out_minute_reg;
  logic [7:0]  out_hour_reg;
  logic [7:0]  out_day_reg;
  logic [7:0]  out_month_reg;
  logic [7:0]  out_year_reg;
  logic [7:0]  out_century_reg;

  datetime_t   pending_dt[$];
  result_t     rtc_expected[$];
  logic [7:0]  fmt_ctl = FMT_RESET;
  logic        steady = 1'b0;
  int          error_count = 0;
  int          idle_left = 0;
  int          stall_cycles = 0;
  logic        next_go;
  datetime_t   next_dt;
  result_t     want;

  datetime_to_cmos_rtc_bytes_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_year         (in_year),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_hour         (in_hour),
    .in_minute       (in_minute),
    .in_second       (in_second),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_invalid     (out_invalid),
    .out_second_reg  (out_second_reg),
    .out_minute_reg  (out_minute_reg),
    .out_hour_reg    (out_hour_reg),
    .out_day_reg     (out_day_reg),
    .out_month_reg   (out_month_reg),
    .out_year_reg    (out_year_reg),
    .out_century_reg (out_century_reg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
    int unsigned n;
    case (mo)
      2: begin
        n = (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0) ? 29 : 28;
      end
      4, 6, 9, 11: n = 30;
      1, 3, 5, 7, 8, 10, 12: n = 31;
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] to_rtc_byte(int unsigned v, logic [7:0] ctl);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = 4'((v / 10) % 10);
    lo = 4'(v % 10);
    if ((ctl & CTL_BIN) != 0) return 8'(v);
    return {hi, lo};
  endfunction

  // Expected register image for one date and time under the given control byte.
  function automatic result_t encode_rtc(datetime_t dt, logic [7:0] ctl);
    result_t     r;
    logic        pm;
    int unsigned hr;
    r = '0;
    if (!(dt.year >= YEAR_MIN && dt.year <= YEAR_MAX &&
          dt.day >= 1 && dt.day <= month_length(dt.year, dt.month) &&
          dt.hour < 24 && dt.minute < 60 && dt.second < 60)) begin
      r.invalid = 1'b1;
      return r;
    end
    pm = 1'b0;
    hr = dt.hour;
    if ((ctl & CTL_24H) == 0) begin
      pm = (hr >= 12);
      hr = hr % 12;
      if (hr == 0) hr = 12;
    end
    r.second_reg  = to_rtc_byte(dt.second, ctl);
    r.minute_reg  = to_rtc_byte(dt.minute, ctl);
    r.hour_reg    = to_rtc_byte(hr, ctl);
    r.day_reg     = to_rtc_byte(dt.day, ctl);
    r.month_reg   = to_rtc_byte(dt.month, ctl);
    r.year_reg    = to_rtc_byte(dt.year % 100, ctl);
    r.century_reg = to_rtc_byte(dt.year / 100, ctl);
    // PM flag goes on after encoding
    if (pm) r.hour_reg = r.hour_reg | PM_FLAG;
    return r;
  endfunction

  function automatic datetime_t mk_dt(int unsigned yr, int unsigned mo, int unsigned dy,
                                      int unsigned hr, int unsigned mi, int unsigned se);
    datetime_t dt;
    dt.year   = 14'(yr);
    dt.month  = 4'(mo);
    dt.day    = 5'(dy);
    dt.hour   = 5'(hr);
    dt.minute = 6'(mi);
    dt.second = 6'(se);
    return dt;
  endfunction

  // Mostly well-formed dates, some with one field out of range, a few pure noise.
  function automatic datetime_t random_dt();
    datetime_t   dt;
    int unsigned pick;
    int unsigned len;
    dt = mk_dt($urandom_range(2000, 2099), $urandom_range(1, 12), 1,
               $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    len = month_length(dt.year, dt.month);
    dt.day = 5'($urandom_range(1, len));
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      dt = mk_dt($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end else if (pick >= 75) begin
      case ($urandom_range(0, 5))
        0: dt.year = 14'($urandom_range(0, 1) ? $urandom_range(0, 1999)
                                               : $urandom_range(2100, 16383));
        1: dt.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
        2: dt.day = 5'((len == 31 || $urandom_range(0, 1)) ? 0 : $urandom_range(len + 1, 31));
        3: dt.hour = 5'($urandom_range(24, 31));
        4: dt.minute = 6'($urandom_range(60, 63));
        default: dt.second = 6'($urandom_range(60, 63));
      endcase
    end
    return dt;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val)
      flag_error($sformatf("%s got 0x%02h want 0x%02h", name, got, exp_val));
  endtask

  task automatic drain_pending();
    do @(negedge clk);
    while (pending_dt.size() != 0 || start || rtc_expected.size() != 0);
  endtask

  task automatic write_format(logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    fmt_ctl    = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_dt.push_back(random_dt());
  endtask

  // Driver: offers the next pending item, holding it while busy, with idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy)
        rtc_expected.push_back(encode_rtc({in_year, in_month, in_day, in_hour,
                                           in_minute, in_second}, fmt_ctl));
      if (!(start && busy)) begin
        next_go = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_dt.size() != 0) begin
          if (!steady && $urandom_range(0, 11) == 0) begin
            idle_left = $urandom_range(0, 15);
          end else begin
            next_dt    = pending_dt.pop_front();
            next_go    = 1'b1;
            in_year   <= next_dt.year;
            in_month  <= next_dt.month;
            in_day    <= next_dt.day;
            in_hour   <= next_dt.hour;
            in_minute <= next_dt.minute;
            in_second <= next_dt.second;
          end
        end
        start <= next_go;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (rtc_expected.size() == 0) begin
        flag_error("result with no transfer outstanding");
      end else begin
        want = rtc_expected.pop_front();
        check_field("invalid", {7'd0, out_invalid}, {7'd0, want.invalid});
        check_field("second_reg", out_second_reg, want.second_reg);
        check_field("minute_reg", out_minute_reg, want.minute_reg);
        check_field("hour_reg", out_hour_reg, want.hour_reg);
        check_field("day_reg", out_day_reg, want.day_reg);
        check_field("month_reg", out_month_reg, want.month_reg);
        check_field("year_reg", out_year_reg, want.year_reg);
        check_field("century_reg", out_century_reg, want.century_reg);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("datetime_to_cmos_rtc_bytes_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset format: 24-hour, BCD
    pending_dt.push_back(mk_dt(2000, 1, 1, 0, 0, 0));
    pending_dt.push_back(mk_dt(2099, 12, 31, 23, 59, 59));
    pending_dt.push_back(mk_dt(2000, 2, 29, 12, 30, 45));  // leap by the 400 rule
    pending_dt.push_back(mk_dt(2004, 2, 29, 6, 7, 8));
    pending_dt.push_back(mk_dt(2001, 2, 29, 6, 7, 8));
    pending_dt.push_back(mk_dt(2004, 2, 30, 6, 7, 8));
    pending_dt.push_back(mk_dt(2021, 4, 31, 10, 20, 30));
    pending_dt.push_back(mk_dt(2021, 6, 30, 10, 20, 30));
    pending_dt.push_back(mk_dt(1999, 12, 31, 23, 59, 59));
    pending_dt.push_back(mk_dt(2100, 1, 1, 0, 0, 0));
    pending_dt.push_back(mk_dt(0, 0, 0, 0, 0, 0));
    pending_dt.push_back(mk_dt(16383, 15, 31, 31, 63, 63));
    pending_dt.push_back(mk_dt(2050, 0, 10, 1, 1, 1));
    pending_dt.push_back(mk_dt(2050, 13, 10, 1, 1, 1));
    pending_dt.push_back(mk_dt(2050, 5, 0, 1, 1, 1));
    pending_dt.push_back(mk_dt(2050, 5, 10, 24, 1, 1));
    pending_dt.push_back(mk_dt(2050, 5, 10, 31, 1, 1));
    pending_dt.push_back(mk_dt(2050, 5, 10, 1, 60, 1));
    pending_dt.push_back(mk_dt(2050, 5, 10, 1, 1, 60));
    pending_dt.push_back(mk_dt(2050, 5, 10, 1, 63, 63));
    queue_random(200);
    drain_pending();

    // 12-hour BCD: midnight, noon and the hours either side
    write_format(8'h00);
    pending_dt.push_back(mk_dt(2042, 7, 4, 0, 15, 0));
    pending_dt.push_back(mk_dt(2042, 7, 4, 11, 59, 59));
    pending_dt.push_back(mk_dt(2042, 7, 4, 12, 0, 0));
    pending_dt.push_back(mk_dt(2042, 7, 4, 13, 0, 1));
    pending_dt.push_back(mk_dt(2042, 7, 4, 23, 45, 30));
    queue_random(230);
    drain_pending();

    write_format(8'hFF);
    queue_random(230);
    drain_pending();

    write_format(CTL_BIN);
    queue_random(230);
    drain_pending();

    // last stretch runs with no idle gaps
    write_format(8'($urandom_range(0, 255)));
    steady = 1'b1;
    queue_random(230);
    drain_pending();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rtc_expected.size() != 0)
      flag_error($sformatf("%0d results never arrived", rtc_expected.size()));
    if (error_count == 0)
      $display("datetime_to_cmos_rtc_bytes_core: match");
    else
      $display("datetime_to_cmos_rtc_bytes_core: mismatch");
    $finish;
  end

endmodule
